// ----- rtl/core/tmr_sensor_voter_with_history_assert.svh -----
// Assertion macros used by the checker file.
`ifndef TMR_SENSOR_VOTER_WITH_HISTORY_ASSERT_SVH
`define TMR_SENSOR_VOTER_WITH_HISTORY_ASSERT_SVH

// Clocked assertion, quiet while reset is active.
`define TSVH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds while reset is active.
`define TSVH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ----- rtl/core/tsvh_pkg.sv -----
package tsvh_pkg;

    // History ring geometry
    localparam int HIST_DEPTH = 16;
    localparam int HIST_IDX_W = $clog2(HIST_DEPTH);
    localparam int HIST_CNT_W = $clog2(HIST_DEPTH + 1);

    // Action codes
    localparam logic ACT_VOTE = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    // Value returned by a pop on an empty ring: -1.0 in Q23.8
    localparam logic signed [31:0] EMPTY_VALUE = -32'sd256;

    // Reset tolerance: 0.5 in Q23.8
    localparam logic [30:0] TOL_RESET = 31'd128;

    // Reciprocal of three: floor(u / 3) == (u * RECIP3) >> RECIP3_SHIFT for 34-bit u
    localparam logic [33:0] RECIP3       = 34'h2_AAAA_AAAB;
    localparam int          RECIP3_SHIFT = 35;

    // Offset that makes the three-sample sum nonnegative (3 * 2^31)
    localparam logic [33:0] SUM3_OFFSET = 34'h1_8000_0000;

    typedef struct packed {
        logic               action;
        logic signed [31:0] sample_a;
        logic signed [31:0] sample_b;
        logic signed [31:0] sample_c;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               vote_ok;
        logic [1:0]         agree_count;
        logic               fault_flag;
        logic               history_empty;
        logic [4:0]         history_count;
    } out_item_t;

endpackage

// ----- rtl/core/tmr_sensor_voter_with_history.sv -----
// Triple redundant sensor voter with a history ring.
// Input channel: in_valid / in_stall with in_data (action and three Q23.8
// samples). A transfer takes place at a rising edge with in_valid high and
// in_stall low. Action vote compares the samples pairwise against the
// tolerance and averages the agreeing ones; action pop returns the oldest
// stored vote. Output channel: out_valid / out_stall with out_data, one result
// per input item, in order.
// Pipeline: each result passes through the input register, the compare/sum
// stage, the reciprocal multiply stage and the final add plus history update
// into the output register.
// Throughput: one item per cycle unless stalled; the four registered stages
// each hold one item, and the last stage updates the ring at most once per item.
// When the receiver stalls, the held result stays unchanged; empty stages
// behind it keep filling, and in_stall rises only once every stage is full.
// Reset (rst_n low, asynchronous) empties the pipeline and the history ring,
// clears the sticky fault flag and sets the tolerance to 0.5.
// cfg_wr_en / cfg_wr_data write the tolerance; write only while idle.
module tmr_sensor_voter_with_history (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [30:0]        cfg_wr_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  tsvh_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output tsvh_pkg::out_item_t out_data
);
    import tsvh_pkg::*;

    function automatic logic [HIST_IDX_W-1:0] hist_wrap(input logic [HIST_IDX_W-1:0] idx);
        logic [HIST_IDX_W-1:0] res;
        if (idx == HIST_IDX_W'(HIST_DEPTH - 1)) begin
            res = '0;
        end
        else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    // Configuration and history state
    logic [30:0]           tol_reg;
    logic [31:0]           hist_mem_reg [HIST_DEPTH];
    logic [HIST_IDX_W-1:0] oldest_reg, oldest_next;
    logic [HIST_IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [HIST_CNT_W-1:0] count_reg, count_next;
    logic                  fault_reg, fault_next;

    // Pipeline valids and enables
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic s1_en, s2_en, s3_en, out_en;

    // Stage 1: input register
    in_item_t s1_reg;

    // Stage 2: compare and sum
    logic        s2_action_reg;
    logic [1:0]  s2_cnt_reg;
    logic        s2_ok_reg;
    logic        s2_use3_reg;
    logic [31:0] s2_pair_reg;
    logic [33:0] s2_u_reg;

    // Stage 3: reciprocal partial products
    logic        s3_action_reg;
    logic [1:0]  s3_cnt_reg;
    logic        s3_ok_reg;
    logic        s3_use3_reg;
    logic [31:0] s3_pair_reg;
    logic [50:0] s3_plo_reg;
    logic [50:0] s3_phi_reg;

    out_item_t out_reg, out_next;

    // Advance each stage when the one ahead frees up
    assign out_en   = !out_valid_reg || !out_stall;
    assign s3_en    = !s3_valid_reg || out_en;
    assign s2_en    = !s2_valid_reg || s3_en;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign in_stall = !s1_en;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Pairwise agreement and sums
    logic signed [32:0] d_ab, d_ac, d_bc, tol_pos, tol_neg;
    logic               ab, ac, bc;
    logic [1:0]         cnt;
    logic [32:0]        sum_ab, sum_ac, sum_bc;
    logic [33:0]        sum3;
    logic [31:0]        pair_avg;

    always_comb
    begin
        tol_pos = $signed({2'b00, tol_reg});
        tol_neg = -tol_pos;
        d_ab = $signed({s1_reg.sample_a[31], s1_reg.sample_a})
             - $signed({s1_reg.sample_b[31], s1_reg.sample_b});
        d_ac = $signed({s1_reg.sample_a[31], s1_reg.sample_a})
             - $signed({s1_reg.sample_c[31], s1_reg.sample_c});
        d_bc = $signed({s1_reg.sample_b[31], s1_reg.sample_b})
             - $signed({s1_reg.sample_c[31], s1_reg.sample_c});
        ab = (d_ab <= tol_pos) && (d_ab >= tol_neg);
        ac = (d_ac <= tol_pos) && (d_ac >= tol_neg);
        bc = (d_bc <= tol_pos) && (d_bc >= tol_neg);
        cnt = 2'(ab) + 2'(ac) + 2'(bc);
        sum_ab = {s1_reg.sample_a[31], s1_reg.sample_a} + {s1_reg.sample_b[31], s1_reg.sample_b};
        sum_ac = {s1_reg.sample_a[31], s1_reg.sample_a} + {s1_reg.sample_c[31], s1_reg.sample_c};
        sum_bc = {s1_reg.sample_b[31], s1_reg.sample_b} + {s1_reg.sample_c[31], s1_reg.sample_c};
        sum3 = {{2{s1_reg.sample_a[31]}}, s1_reg.sample_a}
             + {{2{s1_reg.sample_b[31]}}, s1_reg.sample_b}
             + {{2{s1_reg.sample_c[31]}}, s1_reg.sample_c};
        // Floor halving of a two's complement sum drops the low bit
        if (ab) begin
            pair_avg = sum_ab[32:1];
        end
        else if (ac) begin
            pair_avg = sum_ac[32:1];
        end
        else begin
            pair_avg = sum_bc[32:1];
        end
    end

    // Final quotient and history update
    logic [67:0] q_sum;
    logic [31:0] q3;
    logic [31:0] vote_val;
    logic        push_en;

    always_comb
    begin
        q_sum    = {s3_phi_reg, 17'b0} + 68'(s3_plo_reg);
        q3       = q_sum[RECIP3_SHIFT +: 32];
        // Remove the offset: q3 - 2^31 with q3 below 2^32
        vote_val = s3_use3_reg ? (q3 ^ 32'h8000_0000) : s3_pair_reg;

        oldest_next = oldest_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        fault_next  = fault_reg;
        push_en     = 1'b0;

        out_next.result_value  = '0;
        out_next.vote_ok       = 1'b0;
        out_next.agree_count   = 2'b00;
        out_next.history_empty = 1'b0;

        if (s3_action_reg == ACT_POP) begin
            if (count_reg == '0) begin
                out_next.result_value  = EMPTY_VALUE;
                out_next.history_empty = 1'b1;
            end
            else begin
                out_next.result_value = hist_mem_reg[oldest_reg];
                oldest_next           = hist_wrap(oldest_reg);
                count_next            = count_reg - 1'b1;
            end
        end
        else begin
            out_next.agree_count = s3_cnt_reg;
            if (s3_ok_reg) begin
                out_next.result_value = vote_val;
                out_next.vote_ok      = 1'b1;
                push_en               = 1'b1;
                // Overwrite the oldest entry when the ring is full
                if (count_reg == HIST_CNT_W'(HIST_DEPTH)) begin
                    oldest_next = hist_wrap(oldest_reg);
                end
                else begin
                    count_next = count_reg + 1'b1;
                end
                wr_idx_next = hist_wrap(wr_idx_reg);
            end
            else begin
                fault_next = 1'b1;
            end
        end
        out_next.fault_flag    = fault_next;
        out_next.history_count = 5'(count_next);
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tol_reg       <= TOL_RESET;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            oldest_reg    <= '0;
            wr_idx_reg    <= '0;
            count_reg     <= '0;
            fault_reg     <= 1'b0;
        end
        else begin
            if (cfg_wr_en) begin
                tol_reg <= cfg_wr_data;
            end
            if (s1_en) begin
                s1_valid_reg <= in_valid;
            end
            if (s2_en) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_en) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_en) begin
                out_valid_reg <= s3_valid_reg;
                if (s3_valid_reg) begin
                    oldest_reg <= oldest_next;
                    wr_idx_reg <= wr_idx_next;
                    count_reg  <= count_next;
                    fault_reg  <= fault_next;
                end
            end
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (s1_en && in_valid) begin
            s1_reg <= in_data;
        end
        if (s2_en && s1_valid_reg) begin
            s2_action_reg <= s1_reg.action;
            s2_cnt_reg    <= cnt;
            s2_ok_reg     <= (cnt != 2'b00);
            s2_use3_reg   <= cnt[1];
            s2_pair_reg   <= pair_avg;
            s2_u_reg      <= sum3 + SUM3_OFFSET;
        end
        if (s3_en && s2_valid_reg) begin
            s3_action_reg <= s2_action_reg;
            s3_cnt_reg    <= s2_cnt_reg;
            s3_ok_reg     <= s2_ok_reg;
            s3_use3_reg   <= s2_use3_reg;
            s3_pair_reg   <= s2_pair_reg;
            s3_plo_reg    <= 51'(s2_u_reg[16:0]) * 51'(RECIP3);
            s3_phi_reg    <= 51'(s2_u_reg[33:17]) * 51'(RECIP3);
        end
        if (out_en && s3_valid_reg) begin
            out_reg <= out_next;
        end
    end

    // Write a valid vote into the ring
    always_ff @(posedge clk)
    begin
        if (out_en && s3_valid_reg && push_en) begin
            hist_mem_reg[wr_idx_reg] <= vote_val;
        end
    end

endmodule

// ----- rtl/core/tsvh_checker.sv -----
`include "tmr_sensor_voter_with_history_assert.svh"

module tsvh_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input tsvh_pkg::out_item_t out_data
);
    import tsvh_pkg::*;

    // Remember that a transferred result already showed the fault
    logic fault_seen_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            fault_seen_reg <= 1'b0;
        end
        else if (out_valid && !out_stall && out_data.fault_flag) begin
            fault_seen_reg <= 1'b1;
        end
    end

    `TSVH_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
    `TSVH_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result offered during reset")
    `TSVH_ASSERT(a_fault_sticky, out_valid && fault_seen_reg |-> out_data.fault_flag, "fault flag cleared")
    `TSVH_ASSERT(a_empty_pop, out_valid && out_data.history_empty |-> out_data.history_count == 5'd0 && out_data.result_value == EMPTY_VALUE && !out_data.vote_ok, "bad empty pop result")

endmodule

bind tmr_sensor_voter_with_history tsvh_checker u_tsvh_checker (.*);
